[rtl/dlbr_pkg.sv]
// Package for the dual LFSR bounded random generator.
// Tap masks, reset seeds, queue item type, divider states and LFSR step functions.
// No dependencies.
package dlbr_pkg;

   localparam int MIX_WIDTH   = 16;
   localparam int MOD_WIDTH   = 8;
   localparam int LONG_WIDTH  = 32;
   localparam int SHORT_WIDTH = 31;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [LONG_WIDTH-1:0]  LONG_TAPS        = 32'hB4BC_D35C;
   localparam logic [SHORT_WIDTH-1:0] SHORT_TAPS       = 31'h7A5B_C2E3;
   localparam logic [LONG_WIDTH-1:0]  LONG_SEED_RESET  = 32'hABCD_EFAB;
   localparam logic [SHORT_WIDTH-1:0] SHORT_SEED_RESET = 31'h0000_0001;

   typedef enum logic {
      CSR_SEED_LONG  = 1'b0,
      CSR_SEED_SHORT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic [MIX_WIDTH-1:0] mixed;
      logic [MOD_WIDTH-1:0] modulus;
      logic                 zero_mod;
   } item_type;

   function automatic logic [LONG_WIDTH-1:0] long_step(input logic [LONG_WIDTH-1:0] cur);
      logic [LONG_WIDTH-1:0] nxt;
      nxt = cur >> 1;
      if (cur[0]) begin
         nxt = nxt ^ LONG_TAPS;
      end
      return nxt;
   endfunction

   function automatic logic [SHORT_WIDTH-1:0] short_step(
      input logic [SHORT_WIDTH-1:0] cur);
      logic [SHORT_WIDTH-1:0] nxt;
      nxt = cur >> 1;
      if (cur[0]) begin
         nxt = nxt ^ SHORT_TAPS;
      end
      return nxt;
   endfunction

endpackage

[rtl/dual_lfsr_bounded_random.sv]
// Top level of the dual LFSR bounded random generator.
// Depends on dlbr_pkg, dlbr_front, dlbr_queue, dlbr_divider.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+-----------------
//   request  | req_valid req_ready req_modulus    | valid/ready
//   response | rsp_valid rsp_ready rsp_value      | valid/ready
//   csr      | csr_we csr_index csr_data          | write on csr_we
//
// An accepted request enters the queue and steps the LFSRs, unless csr_we is
// high then; the seed write wins. The divider takes one request at a
// time: load, one remainder step per dividend bit, then the result register.
// The queue holds QueueDepth requests; req_ready drops when it is full.
// Reset reloads both LFSRs with their reset seeds; no clearing pass.
module dual_lfsr_bounded_random #(
   parameter int QueueDepth = dlbr_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [dlbr_pkg::LONG_WIDTH-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dlbr_pkg::MOD_WIDTH-1:0]  req_modulus,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dlbr_pkg::MOD_WIDTH-1:0]  rsp_value
);

   dlbr_pkg::item_type push_item, pop_item;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   dlbr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_modulus (req_modulus),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   dlbr_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   dlbr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

endmodule

[rtl/dlbr_front.sv]
// Front end: holds both LFSRs, steps them per request, forms the queue item.
// Depends on dlbr_pkg.
module dlbr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [dlbr_pkg::LONG_WIDTH-1:0]    csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dlbr_pkg::MOD_WIDTH-1:0]     req_modulus,
   output logic                               push_valid,
   input  logic                               push_ready,
   output dlbr_pkg::item_type                 push_item
);

   logic [dlbr_pkg::LONG_WIDTH-1:0]  long_ff,  long_in;
   logic [dlbr_pkg::SHORT_WIDTH-1:0] short_ff, short_in;
   logic [dlbr_pkg::LONG_WIDTH-1:0]  long_next;
   logic [dlbr_pkg::SHORT_WIDTH-1:0] short_next;
   logic                             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   always_comb begin
      long_next  = dlbr_pkg::long_step(dlbr_pkg::long_step(long_ff));
      short_next = dlbr_pkg::short_step(short_ff);

      push_item.mixed    = long_next[dlbr_pkg::MIX_WIDTH-1:0]
                         ^ short_next[dlbr_pkg::MIX_WIDTH-1:0];
      push_item.modulus  = req_modulus;
      push_item.zero_mod = (req_modulus == '0);

      long_in  = long_ff;
      short_in = short_ff;
      if (csr_we) begin
         if (dlbr_pkg::csr_index_type'(csr_index) == dlbr_pkg::CSR_SEED_LONG) begin
            long_in = csr_data;
         end else begin
            short_in = csr_data[dlbr_pkg::SHORT_WIDTH-1:0];
         end
      end else if (accept) begin
         long_in  = long_next;
         short_in = short_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff  <= dlbr_pkg::LONG_SEED_RESET;
         short_ff <= dlbr_pkg::SHORT_SEED_RESET;
      end else begin
         long_ff  <= long_in;
         short_ff <= short_in;
      end
   end

endmodule

[rtl/dlbr_queue.sv]
// Small FIFO between front end and divider.
// Depends on dlbr_pkg.
module dlbr_queue #(
   parameter int QueueDepth = dlbr_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  dlbr_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output dlbr_pkg::item_type pop_item
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);

   dlbr_pkg::item_type    mem [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff,  count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CntWidth'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/dlbr_divider.sv]
// Back end: restoring remainder, one dividend bit per cycle, plus result register.
// Depends on dlbr_pkg.
module dlbr_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  dlbr_pkg::item_type             pop_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dlbr_pkg::MOD_WIDTH-1:0] rsp_value
);

   localparam int CntWidth = $clog2(dlbr_pkg::MIX_WIDTH);

   dlbr_pkg::div_state_type             state_ff, state_in;
   logic [dlbr_pkg::MIX_WIDTH-1:0]      dividend_ff, dividend_in;
   logic [dlbr_pkg::MOD_WIDTH-1:0]      modulus_ff, modulus_in;
   logic                                zero_ff, zero_in;
   logic [dlbr_pkg::MOD_WIDTH-1:0]      rem_ff, rem_in;
   logic [CntWidth-1:0]                 count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [dlbr_pkg::MOD_WIDTH-1:0]      rsp_value_ff, rsp_value_in;
   logic [dlbr_pkg::MOD_WIDTH:0]        trial;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   always_comb begin
      state_in     = state_ff;
      dividend_in  = dividend_ff;
      modulus_in   = modulus_ff;
      zero_in      = zero_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_value_in = rsp_value_ff;
      pop_ready    = 1'b0;
      trial        = {rem_ff, dividend_ff[dlbr_pkg::MIX_WIDTH-1]};

      unique case (state_ff)
         dlbr_pkg::DIV_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               dividend_in = pop_item.mixed;
               modulus_in  = pop_item.modulus;
               zero_in     = pop_item.zero_mod;
               rem_in      = '0;
               count_in    = '0;
               state_in    = dlbr_pkg::DIV_RUN;
            end
         end
         dlbr_pkg::DIV_RUN: begin
            if (trial >= {1'b0, modulus_ff}) begin
               rem_in = dlbr_pkg::MOD_WIDTH'(trial - {1'b0, modulus_ff});
            end else begin
               rem_in = trial[dlbr_pkg::MOD_WIDTH-1:0];
            end
            dividend_in = dividend_ff << 1;
            count_in    = count_ff + 1'b1;
            if (count_ff == CntWidth'(dlbr_pkg::MIX_WIDTH - 1)) begin
               state_in = dlbr_pkg::DIV_DONE;
            end
         end
         dlbr_pkg::DIV_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = zero_ff ? '0 : rem_ff;
               state_in     = dlbr_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = dlbr_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlbr_pkg::DIV_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff  <= dividend_in;
      modulus_ff   <= modulus_in;
      zero_ff      <= zero_in;
      rem_ff       <= rem_in;
      count_ff     <= count_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

[rtl/dlbr_checker.sv]
// Port-level checker for dual_lfsr_bounded_random, with its bind statement.
// Depends on dlbr_pkg.
module dlbr_props #(
   parameter int QueueDepth = dlbr_pkg::QUEUE_DEPTH
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dlbr_pkg::MOD_WIDTH-1:0]  rsp_value
);

   // queue, divider and result register
   localparam int Capacity = QueueDepth + 2;
   localparam int OutWidth = $clog2(Capacity + 2);

   logic [OutWidth-1:0] pending_ff, pending_in;
   logic                req_take, rsp_take;

   assign req_take = req_valid & req_ready;
   assign rsp_take = rsp_valid & rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled response changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without pending request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= OutWidth'(Capacity))
      else $error("more requests in flight than storage");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_value))
      else $error("response value unknown");

endmodule

bind dual_lfsr_bounded_random dlbr_props #(.QueueDepth(QueueDepth)) u_checker (.*);

[sim/dlbr_checker.sv]
// Checker for dual_lfsr_bounded_random: tracks seed writes and requests, predicts each
// bounded value and compares it with the responses in order.
// Depends on dlbr_pkg for port widths.
module dlbr_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [dlbr_pkg::LONG_WIDTH-1:0] csr_data,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [dlbr_pkg::MOD_WIDTH-1:0]  req_modulus,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [dlbr_pkg::MOD_WIDTH-1:0]  rsp_value,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] GALOIS_LONG  = 32'hB4BC_D35C;
   localparam logic [30:0] GALOIS_SHORT = 31'h7A5B_C2E3;
   localparam logic [31:0] LONG_START   = 32'hABCD_EFAB;
   localparam logic [30:0] SHORT_START  = 31'h0000_0001;

   logic [31:0] long_lfsr;
   logic [30:0] short_lfsr;
   logic [7:0]  expected_values[$];
   logic [7:0]  want;

   function automatic logic [31:0] shift_long(input logic [31:0] cur);
      return cur[0] ? ((cur >> 1) ^ GALOIS_LONG) : (cur >> 1);
   endfunction

   function automatic logic [30:0] shift_short(input logic [30:0] cur);
      return cur[0] ? ((cur >> 1) ^ GALOIS_SHORT) : (cur >> 1);
   endfunction

   // advances both generators for one request and returns the bounded value
   function automatic logic [7:0] bounded_draw(input logic [7:0] modulus);
      logic [15:0] mixed;
      long_lfsr  = shift_long(shift_long(long_lfsr));
      short_lfsr = shift_short(short_lfsr);
      mixed      = long_lfsr[15:0] ^ short_lfsr[15:0];
      if (modulus == 8'd0) begin
         return 8'd0;
      end
      return 8'(mixed % modulus);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         long_lfsr  = LONG_START;
         short_lfsr = SHORT_START;
         expected_values.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response %0d with no request outstanding", $realtime,
                           rsp_value);
               end
            end else begin
               want = expected_values.pop_front();
               if (rsp_value !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: value expected %0d actual %0d", $realtime, want,
                              rsp_value);
                  end
               end
            end
         end
         if (csr_we) begin
            case (dlbr_pkg::csr_index_type'(csr_index))
               dlbr_pkg::CSR_SEED_LONG:  long_lfsr  = csr_data;
               dlbr_pkg::CSR_SEED_SHORT: short_lfsr = csr_data[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_values.push_back(bounded_draw(req_modulus));
         end
      end
      pending = expected_values.size();
   end

endmodule

[sim/tb.sv]
// Testbench top for dual_lfsr_bounded_random: drives seeds and requests with random
// idling and back-pressure, and reports the verdict from dlbr_checker.
// Depends on dlbr_pkg, dlbr_checker and the RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 255;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 40;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [0:0]                      csr_index;
   logic [dlbr_pkg::LONG_WIDTH-1:0] csr_data;
   logic                            req_valid;
   logic                            req_ready;
   logic [dlbr_pkg::MOD_WIDTH-1:0]  req_modulus;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [dlbr_pkg::MOD_WIDTH-1:0]  rsp_value;

   int fail_count;
   int pending;
   int rsp_hold_left;
   bit req_idle_on;
   bit rsp_stall_on;
   int phase;
   int item;

   dual_lfsr_bounded_random u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_modulus (req_modulus),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value)
   );

   dlbr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_modulus (req_modulus),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: long hold-off when asked, otherwise random stalls while rsp_stall_on is set
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall_on && $urandom_range(99) < 14) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic offer_request(input logic [dlbr_pkg::MOD_WIDTH-1:0] modulus);
      if (req_idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_modulus <= modulus;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding response
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_seed(input dlbr_pkg::csr_index_type index,
                             input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [dlbr_pkg::MOD_WIDTH-1:0] pick_modulus();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(4))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd128;
            3:       return 8'd254;
            default: return 8'd255;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = dlbr_pkg::CSR_SEED_LONG;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_modulus   = '0;
      rsp_hold_left = 0;
      req_idle_on   = 1'b0;
      rsp_stall_on  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset seeds, modulus extremes and zero modulus
      offer_request(8'd1);
      offer_request(8'd255);
      offer_request(8'd0);
      offer_request(8'd128);
      offer_request(8'd2);
      offer_request(8'd3);
      offer_request(8'h55);
      offer_request(8'hAA);

      // long generator locked at zero
      settle();
      write_seed(dlbr_pkg::CSR_SEED_LONG, 32'h0000_0000);
      offer_request(8'd255);
      offer_request(8'd16);
      offer_request(8'd0);

      // both locked at zero
      settle();
      write_seed(dlbr_pkg::CSR_SEED_SHORT, 32'h0000_0000);
      offer_request(8'd200);
      offer_request(8'd1);

      // all-ones seeds; top bit of the short seed is dropped
      settle();
      write_seed(dlbr_pkg::CSR_SEED_LONG, 32'hFFFF_FFFF);
      write_seed(dlbr_pkg::CSR_SEED_SHORT, 32'hFFFF_FFFF);
      offer_request(8'd255);
      offer_request(8'd254);
      offer_request(8'd0);
      offer_request(8'd7);

      settle();
      write_seed(dlbr_pkg::CSR_SEED_LONG, 32'h0000_0001);
      write_seed(dlbr_pkg::CSR_SEED_SHORT, 32'h0000_0001);
      offer_request(8'd255);
      offer_request(8'd97);

      settle();
      write_seed(dlbr_pkg::CSR_SEED_LONG, 32'h0000_0000);
      write_seed(dlbr_pkg::CSR_SEED_SHORT, 32'h7FFF_FFFF);
      offer_request(8'd255);
      offer_request(8'd100);

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         req_idle_on  = (phase != 0);
         rsp_stall_on = (phase != 0);
         write_seed(dlbr_pkg::CSR_SEED_LONG, pick_seed());
         if (phase != PHASES - 1) begin
            write_seed(dlbr_pkg::CSR_SEED_SHORT, pick_seed());
         end
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 2 && item == 20) begin
               rsp_hold_left = LONG_HOLD;
            end
            if (phase == 4 && item == 128) begin
               settle();
            end
            offer_request(pick_modulus());
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[dual_lfsr_bounded_random.f]
rtl/dlbr_pkg.sv
rtl/dlbr_front.sv
rtl/dlbr_queue.sv
rtl/dlbr_divider.sv
rtl/dual_lfsr_bounded_random.sv
rtl/dlbr_checker.sv
sim/dlbr_checker.sv
sim/tb.sv
